/* rtl/core/lah_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lah_pkg
// Types, constants and fixed-point helpers for the humidity coupler.
// ----------------------------------------------------------------------------
package lah_pkg;

   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   localparam int CNT_W     = 9;
   localparam int RATE_W    = 10;
   localparam int SCALE_W   = 31;
   localparam int CSR_IDX_W = 3;
   localparam int PROD_W    = 66;
   localparam int DVD_W     = DATA_W + FRAC_BITS;

   localparam logic signed [DATA_W-1:0] TK_Q    = 32'sd17901814;
   localparam logic signed [DATA_W-1:0] KO2_Q   = 32'sd3002;
   localparam logic signed [DATA_W-1:0] TENTH_Q = 32'sd6554;
   localparam logic signed [DATA_W-1:0] QMIN_Q  = 32'sd1638400;
   localparam logic [DATA_W-1:0]        DECAY_Q32 = 32'd4085499269;
   localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFFFFFF;
   localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh80000000;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PATH_SCALE = 3'd0,
      REG_COEF_ZERO  = 3'd1,
      REG_COEF_ONE   = 3'd2,
      REG_COEF_TWO   = 3'd3,
      REG_COEF_THREE = 3'd4,
      REG_SAMPLE_RATE = 3'd5
   } csr_index_type;

   typedef enum logic [4:0] {
      CMD_NOP, CMD_LOAD, CMD_MUL_KP, CMD_FIN, CMD_MUL_P, CMD_DIV_TK, CMD_SET_V,
      CMD_MUL_E, CMD_SET_E, CMD_MUL_C3, CMD_ADD_C2, CMD_MUL_ACC, CMD_ADD_C1,
      CMD_ADD_C0, CMD_DIV_PS, CMD_SET_EST, CMD_MUL_S3, CMD_ADD_2C2, CMD_SET_SLOPE,
      CMD_SET_BASE, CMD_DIV_STEADY, CMD_SET_GAIN, CMD_MUL_G, CMD_DIV_SLOPE,
      CMD_SET_RC, CMD_SET_U, CMD_FINISH
   } cmd_type;

   typedef enum logic [5:0] {
      S_IDLE, S_KP, S_KPF, S_P, S_PF, S_DVO, S_V, S_ME, S_SE,
      S_C3, S_A2, S_M1, S_A1, S_M0, S_A0, S_DC, S_EST,
      S_S3, S_SA2, S_SM1, S_SA1, S_DS, S_SL, S_BASE, S_DST, S_GAIN,
      S_MG, S_FG, S_DD, S_RC, S_U, S_OUT, S_WAIT
   } state_type;

   typedef struct packed {
      logic div_done;
      logic out_busy;
   } status_type;

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] x);
      if (x > PROD_W'(Q_MAX)) return Q_MAX;
      if (x < PROD_W'(Q_MIN)) return Q_MIN;
      return x[DATA_W-1:0];
   endfunction

   function automatic logic signed [DATA_W-1:0] qadd(input logic signed [DATA_W-1:0] a,
                                                     input logic signed [DATA_W-1:0] b);
      return sat32(PROD_W'(a) + PROD_W'(b));
   endfunction

   function automatic logic signed [DATA_W-1:0] qsub(input logic signed [DATA_W-1:0] a,
                                                     input logic signed [DATA_W-1:0] b);
      return sat32(PROD_W'(a) - PROD_W'(b));
   endfunction

   // round half up, floor shift, saturate
   function automatic logic signed [DATA_W-1:0] qfin(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] r;
      r = p + (PROD_W'(1) <<< (FRAC_BITS - 1));
      return sat32(r >>> FRAC_BITS);
   endfunction

endpackage
`default_nettype wire

/* rtl/core/lah_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lah_div
// Restoring divider, one quotient bit per cycle, saturated signed result.
// ----------------------------------------------------------------------------
module lah_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [lah_pkg::DVD_W-1:0]     dvd,
   input  wire logic [lah_pkg::DATA_W-1:0]    dvs,
   input  wire logic                          neg,
   output logic                               done,
   output logic signed [lah_pkg::DATA_W-1:0]  quo
);
   import lah_pkg::*;

   localparam int IT_W = $clog2(DVD_W);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [IT_W-1:0]     it_ff, it_in;
   logic [DVD_W-1:0]    dq_ff, dq_in;
   logic [DATA_W-1:0]   rem_ff, rem_in;
   logic [DATA_W-1:0]   dvs_ff, dvs_in;
   logic                neg_ff, neg_in;
   logic [DATA_W:0]     trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      it_in   = it_ff;
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      trial   = {rem_ff, dq_ff[DVD_W-1]};
      if (start) begin
         busy_in = 1'b1;
         it_in   = '0;
         dq_in   = dvd;
         rem_in  = '0;
         dvs_in  = dvs;
         neg_in  = neg;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = DATA_W'(trial - {1'b0, dvs_ff});
            dq_in  = {dq_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DATA_W-1:0];
            dq_in  = {dq_ff[DVD_W-2:0], 1'b0};
         end
         it_in = it_ff + 1'b1;
         if (it_ff == IT_W'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      it_ff  <= it_in;
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   always_comb begin
      if (neg_ff) begin
         if (dq_ff > DVD_W'(33'h080000000)) quo = Q_MIN;
         else                               quo = DATA_W'(-dq_ff);
      end else begin
         if (dq_ff > DVD_W'(Q_MAX))         quo = Q_MAX;
         else                               quo = dq_ff[DATA_W-1:0];
      end
   end

   assign done = done_ff;

endmodule
`default_nettype wire

/* rtl/core/lah_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lah_datapath
// Configuration, sample and coupling registers, shared multiplier, divider.
// ----------------------------------------------------------------------------
module lah_datapath #(
   parameter int COUPLE_LIMIT = 300
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire lah_pkg::cmd_type                 cmd,
   output lah_pkg::status_type                   status,
   input  wire logic                             csr_write,
   input  wire logic [lah_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [lah_pkg::DATA_W-1:0]       csr_wdata,
   input  wire logic signed [lah_pkg::DATA_W-1:0] req_detector_volts,
   input  wire logic signed [lah_pkg::DATA_W-1:0] req_static_pressure,
   input  wire logic signed [lah_pkg::DATA_W-1:0] req_air_temp_c,
   input  wire logic signed [lah_pkg::DATA_W-1:0] req_dynamic_pressure,
   input  wire logic signed [lah_pkg::DATA_W-1:0] req_reference_humidity,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic signed [lah_pkg::DATA_W-1:0]     rsp_humidity
);
   import lah_pkg::*;

   typedef logic signed [DATA_W-1:0] q_type;

   logic [SCALE_W-1:0] ps_ff, ps_in;
   q_type c0_ff, c0_in, c1_ff, c1_in, c2_ff, c2_in, c3_ff, c3_in;
   logic [RATE_W-1:0] rate_ff, rate_in;

   q_type volts_ff, volts_in, pstat_ff, pstat_in, qdyn_ff, qdyn_in, rref_ff, rref_in;
   q_type tk_ff, tk_in, x_ff, x_in, v_ff, v_in, acc_ff, acc_in;
   q_type est_ff, est_in, slope_ff, slope_in, d_ff, d_in, gain_ff, gain_in;
   q_type rc_ff, rc_in, prev_ff, prev_in, out_ff, out_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DATA_W:0]  e_ff, e_in;
   logic             step_ff, step_in;
   logic             valid_ff, valid_in;

   logic signed [DATA_W:0] mul_a, mul_b;
   q_type c3x3, fin, mag, base, del, num, den;
   logic [DATA_W-1:0] num_mag, den_mag, dvs;
   logic [DVD_W-1:0]  dvd;
   logic              div_start, div_neg, div_done;
   q_type             quo;
   logic [RATE_W-1:0] rate_eff;
   logic [DATA_W+1:0] rom;
   logic [64:0]       e_next;

   assign c3x3     = sat32(PROD_W'(c3_ff) * PROD_W'(3));
   assign fin      = qfin(prod_ff);
   assign mag      = (d_ff == Q_MIN) ? Q_MAX : ((d_ff < 0) ? -d_ff : d_ff);
   assign base     = (cnt_ff == CNT_W'(1)) ? est_ff : prev_ff;
   assign rate_eff = (rate_ff == '0) ? RATE_W'(1) : rate_ff;
   assign rom      = ({1'b0, e_ff} + (DATA_W+2)'(32768)) >> FRAC_BITS;
   assign e_next   = ({1'b0, prod_ff[63:0]} + 65'h080000000) >> 32;
   assign del      = (d_ff == '0) ? '0 : ((d_ff < 0) ? -quo : quo);

   // multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd)
         CMD_MUL_KP:  begin mul_a = {2'b0, ps_ff};        mul_b = (DATA_W+1)'(KO2_Q); end
         CMD_MUL_P:   begin mul_a = (DATA_W+1)'(acc_ff);  mul_b = (DATA_W+1)'(pstat_ff); end
         CMD_MUL_E:   begin mul_a = {1'b0, e_ff[DATA_W-1:0]}; mul_b = {1'b0, DECAY_Q32}; end
         CMD_MUL_C3:  begin mul_a = (DATA_W+1)'(x_ff);    mul_b = (DATA_W+1)'(c3_ff); end
         CMD_MUL_ACC: begin mul_a = (DATA_W+1)'(x_ff);    mul_b = (DATA_W+1)'(acc_ff); end
         CMD_MUL_S3:  begin mul_a = (DATA_W+1)'(x_ff);    mul_b = (DATA_W+1)'(c3x3); end
         CMD_MUL_G:   begin mul_a = (DATA_W+1)'(mag);     mul_b = (DATA_W+1)'(gain_ff); end
         default: ;
      endcase
   end

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   // divider operands
   always_comb begin
      num = acc_ff;
      den = tk_ff;
      case (cmd)
         CMD_DIV_PS:    den = {1'b0, ps_ff};
         CMD_DIV_SLOPE: den = slope_ff;
         default: ;
      endcase
      num_mag = (num < 0) ? DATA_W'(-(DATA_W+1)'(num)) : num;
      den_mag = (den < 0) ? DATA_W'(-(DATA_W+1)'(den)) : den;
      if (den_mag == '0) den_mag = DATA_W'(1);
      dvd       = {num_mag, FRAC_BITS'(0)};
      dvs       = den_mag;
      div_neg   = num[DATA_W-1] ^ den[DATA_W-1];
      div_start = 1'b1;
      case (cmd)
         CMD_DIV_TK, CMD_DIV_PS, CMD_DIV_SLOPE: ;
         CMD_DIV_STEADY: begin
            dvd     = DVD_W'(1 << FRAC_BITS) + DVD_W'(rate_eff) * DVD_W'(500);
            dvs     = DATA_W'(rate_eff) * DATA_W'(1000);
            div_neg = 1'b0;
         end
         default: div_start = 1'b0;
      endcase
   end

   lah_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .dvd   (dvd),
      .dvs   (dvs),
      .neg   (div_neg),
      .done  (div_done),
      .quo   (quo)
   );

   always_comb begin
      ps_in = ps_ff;  c0_in = c0_ff;  c1_in = c1_ff;  c2_in = c2_ff;
      c3_in = c3_ff;  rate_in = rate_ff;
      volts_in = volts_ff;  pstat_in = pstat_ff;  qdyn_in = qdyn_ff;  rref_in = rref_ff;
      tk_in = tk_ff;  x_in = x_ff;  v_in = v_ff;  acc_in = acc_ff;
      est_in = est_ff;  slope_in = slope_ff;  d_in = d_ff;  gain_in = gain_ff;
      rc_in = rc_ff;  prev_in = prev_ff;  out_in = out_ff;
      cnt_in = cnt_ff;  e_in = e_ff;  step_in = step_ff;
      valid_in = valid_ff && rsp_stall;

      if (csr_write) begin
         case (csr_index)
            REG_PATH_SCALE: begin
               ps_in = csr_wdata[SCALE_W-1:0];
               if (ps_in == '0) ps_in = SCALE_W'(1);
            end
            REG_COEF_ZERO:   c0_in = csr_wdata;
            REG_COEF_ONE:    c1_in = csr_wdata;
            REG_COEF_TWO:    c2_in = csr_wdata;
            REG_COEF_THREE:  c3_in = csr_wdata;
            REG_SAMPLE_RATE: rate_in = csr_wdata[RATE_W-1:0];
            default: ;
         endcase
      end

      case (cmd)
         CMD_LOAD: begin
            volts_in = req_detector_volts;
            pstat_in = req_static_pressure;
            qdyn_in  = req_dynamic_pressure;
            rref_in  = req_reference_humidity;
            tk_in    = qadd(req_air_temp_c, TK_Q);
         end
         CMD_FIN:     acc_in = fin;
         CMD_SET_V: begin
            v_in    = qsub(volts_ff, quo);
            x_in    = v_in;
            step_in = (cnt_ff < CNT_W'(COUPLE_LIMIT));
            if (step_in) cnt_in = cnt_ff + 1'b1;
         end
         CMD_SET_E: begin
            if (step_ff) e_in = e_ff[DATA_W] ? {1'b0, DECAY_Q32} : e_next[DATA_W:0];
         end
         CMD_ADD_C2:  acc_in = qadd(c2_ff, fin);
         CMD_ADD_C1:  acc_in = qadd(c1_ff, fin);
         CMD_ADD_C0:  acc_in = qadd(c0_ff, fin);
         CMD_ADD_2C2: acc_in = qadd(qadd(c2_ff, c2_ff), fin);
         CMD_SET_EST: est_in = quo;
         CMD_SET_SLOPE: slope_in = (quo < TENTH_Q) ? TENTH_Q : quo;
         CMD_SET_BASE: begin
            d_in = qsub(base, rref_ff);
            if (cnt_ff == CNT_W'(1)) rc_in = '0;
         end
         CMD_SET_GAIN: gain_in = sat32(PROD_W'(rom) + PROD_W'(quo));
         CMD_SET_RC:   rc_in = qadd(rc_ff, del);
         CMD_SET_U:    x_in = qsub(v_ff, rc_ff);
         CMD_FINISH: begin
            prev_in  = quo;
            out_in   = quo;
            valid_in = 1'b1;
            if (qdyn_ff < QMIN_Q) begin
               cnt_in = '0;
               e_in   = {1'b1, DATA_W'(0)};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ps_ff    <= SCALE_W'(1 << FRAC_BITS);
         c0_ff    <= '0;
         c1_ff    <= '0;
         c2_ff    <= '0;
         c3_ff    <= '0;
         rate_ff  <= RATE_W'(25);
         rc_ff    <= '0;
         prev_ff  <= '0;
         cnt_ff   <= '0;
         e_ff     <= {1'b1, DATA_W'(0)};
         step_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         ps_ff    <= ps_in;
         c0_ff    <= c0_in;
         c1_ff    <= c1_in;
         c2_ff    <= c2_in;
         c3_ff    <= c3_in;
         rate_ff  <= rate_in;
         rc_ff    <= rc_in;
         prev_ff  <= prev_in;
         cnt_ff   <= cnt_in;
         e_ff     <= e_in;
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
      volts_ff <= volts_in;
      pstat_ff <= pstat_in;
      qdyn_ff  <= qdyn_in;
      rref_ff  <= rref_in;
      tk_ff    <= tk_in;
      x_ff     <= x_in;
      v_ff     <= v_in;
      acc_ff   <= acc_in;
      est_ff   <= est_in;
      slope_ff <= slope_in;
      d_ff     <= d_in;
      gain_ff  <= gain_in;
      out_ff   <= out_in;
      prod_ff  <= prod_in;
   end

   assign status.div_done = div_done;
   assign status.out_busy = valid_ff && rsp_stall;
   assign rsp_valid       = valid_ff;
   assign rsp_humidity    = out_ff;

endmodule
`default_nettype wire

/* rtl/core/lah_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lah_ctrl
// Sequencer: walks one item through the datapath operations.
// ----------------------------------------------------------------------------
module lah_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire lah_pkg::status_type  status,
   output lah_pkg::cmd_type          cmd
);
   import lah_pkg::*;

   state_type state_ff, state_in;
   state_type ret_ff, ret_in;
   logic      pass_ff, pass_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= S_IDLE;
         pass_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         pass_ff  <= pass_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      pass_in   = pass_ff;
      cmd       = CMD_NOP;
      req_stall = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            pass_in   = 1'b0;
            if (req_valid) begin
               cmd      = CMD_LOAD;
               state_in = S_KP;
            end
         end
         S_KP:  begin cmd = CMD_MUL_KP; state_in = S_KPF; end
         S_KPF: begin cmd = CMD_FIN;    state_in = S_P; end
         S_P:   begin cmd = CMD_MUL_P;  state_in = S_PF; end
         S_PF:  begin cmd = CMD_FIN;    state_in = S_DVO; end
         S_DVO: begin cmd = CMD_DIV_TK; ret_in = S_V; state_in = S_WAIT; end
         S_V:   begin cmd = CMD_SET_V;  state_in = S_ME; end
         S_ME:  begin cmd = CMD_MUL_E;  state_in = S_SE; end
         S_SE:  begin cmd = CMD_SET_E;  state_in = S_C3; end
         S_C3:  begin cmd = CMD_MUL_C3; state_in = S_A2; end
         S_A2:  begin cmd = CMD_ADD_C2; state_in = S_M1; end
         S_M1:  begin cmd = CMD_MUL_ACC; state_in = S_A1; end
         S_A1:  begin cmd = CMD_ADD_C1; state_in = S_M0; end
         S_M0:  begin cmd = CMD_MUL_ACC; state_in = S_A0; end
         S_A0:  begin cmd = CMD_ADD_C0; state_in = S_DC; end
         S_DC: begin
            cmd      = CMD_DIV_PS;
            ret_in   = pass_ff ? S_OUT : S_EST;
            state_in = S_WAIT;
         end
         S_EST: begin cmd = CMD_SET_EST; state_in = S_S3; end
         S_S3:  begin cmd = CMD_MUL_S3;  state_in = S_SA2; end
         S_SA2: begin cmd = CMD_ADD_2C2; state_in = S_SM1; end
         S_SM1: begin cmd = CMD_MUL_ACC; state_in = S_SA1; end
         S_SA1: begin cmd = CMD_ADD_C1;  state_in = S_DS; end
         S_DS:  begin cmd = CMD_DIV_PS;  ret_in = S_SL; state_in = S_WAIT; end
         S_SL:  begin cmd = CMD_SET_SLOPE; state_in = S_BASE; end
         S_BASE: begin cmd = CMD_SET_BASE; state_in = S_DST; end
         S_DST: begin cmd = CMD_DIV_STEADY; ret_in = S_GAIN; state_in = S_WAIT; end
         S_GAIN: begin cmd = CMD_SET_GAIN; state_in = S_MG; end
         S_MG:  begin cmd = CMD_MUL_G;  state_in = S_FG; end
         S_FG:  begin cmd = CMD_FIN;    state_in = S_DD; end
         S_DD:  begin cmd = CMD_DIV_SLOPE; ret_in = S_RC; state_in = S_WAIT; end
         S_RC:  begin cmd = CMD_SET_RC; state_in = S_U; end
         S_U: begin
            cmd      = CMD_SET_U;
            pass_in  = 1'b1;
            state_in = S_C3;
         end
         S_OUT: begin
            if (!status.out_busy) begin
               cmd      = CMD_FINISH;
               state_in = S_IDLE;
            end
         end
         S_WAIT: begin
            if (status.div_done) state_in = ret_ff;
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule
`default_nettype wire

/* rtl/core/lyman_alpha_humidity_coupler.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lyman_alpha_humidity_coupler
// Lyman-alpha humidity with oxygen correction and coupling to a reference.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  detector, pressures, temp, ref
//   rsp      out        rsp_valid/rsp_stall  humidity
//   csr      in         csr_write            csr_index, csr_wdata
//
// One item at a time: six divides on the shared restoring divider each
// pass through issue, 48 quotient bits and done; the rest are multiply
// and add steps.
// Reset is synchronous and restores register defaults and coupling state.
// A held result stalls only the final write; the next item is taken while
// the result waits in the output register.
// ----------------------------------------------------------------------------
module lyman_alpha_humidity_coupler #(
   parameter int COUPLE_LIMIT = 300
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic signed [lah_pkg::DATA_W-1:0] req_detector_volts,
   input  wire logic signed [lah_pkg::DATA_W-1:0] req_static_pressure,
   input  wire logic signed [lah_pkg::DATA_W-1:0] req_air_temp_c,
   input  wire logic signed [lah_pkg::DATA_W-1:0] req_dynamic_pressure,
   input  wire logic signed [lah_pkg::DATA_W-1:0] req_reference_humidity,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic signed [lah_pkg::DATA_W-1:0]      rsp_humidity,
   input  wire logic                              csr_write,
   input  wire logic [lah_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [lah_pkg::DATA_W-1:0]        csr_wdata
);
   import lah_pkg::*;

   cmd_type    cmd;
   status_type status;

   lah_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lah_datapath #(
      .COUPLE_LIMIT (COUPLE_LIMIT)
   ) u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .status                 (status),
      .csr_write              (csr_write),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata),
      .req_detector_volts     (req_detector_volts),
      .req_static_pressure    (req_static_pressure),
      .req_air_temp_c         (req_air_temp_c),
      .req_dynamic_pressure   (req_dynamic_pressure),
      .req_reference_humidity (req_reference_humidity),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_humidity           (rsp_humidity)
   );

endmodule
`default_nettype wire
